// ===== src/gb3_pkg.sv =====
// Shared types and constants for the 3x3 Gaussian blur.
// No dependencies; every other file imports this package.
`default_nettype none

package gb3_pkg;

  localparam int PIX_W     = 8;
  localparam int COL_W     = 12;
  localparam int DIM_W     = 13;
  localparam int WGT_W     = 16;
  localparam int FRAC_BITS = 16;
  localparam int MAX_WIDTH = 4096;
  localparam int MAX_ROWS  = 4096;
  localparam int SUM_W     = 28;
  localparam int NSUM_W    = PIX_W + 2;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WC     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WK     = 3'd4;

  localparam logic [DIM_W-1:0] RST_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 13'd480;
  localparam logic [WGT_W-1:0] RST_WC     = 16'd7476;
  localparam logic [WGT_W-1:0] RST_WE     = 16'd7330;
  localparam logic [WGT_W-1:0] RST_WK     = 16'd7185;

  typedef logic [2:0][2:0][PIX_W-1:0] window_t;

  // One input pixel's worth of work: window snapshot plus the results it owes.
  // due bits: 0 row above/left, 1 row above/right, 2 last row/left, 3 last row/right
  typedef struct packed {
    window_t          win;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] row;
    logic [3:0]       due;
    logic             col_is0;
    logic             col_is1;
    logic             row_is0;
    logic             row_is1;
  } job_t;

endpackage

`default_nettype wire

// ===== src/gb3_front.sv =====
// Front end: pixel intake, raster counters, two line buffers and the 3x3 window.
// Emits one job per pixel that makes results due. Depends on gb3_pkg.
`default_nettype none

module gb3_front
  import gb3_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [DIM_W-1:0] w_eff,
  input  wire logic [DIM_W-1:0] h_eff,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [PIX_W-1:0] pixel_in,
  input  wire logic             q_full,
  output logic                  push,
  output job_t                  push_job
);

  logic [COL_W-1:0] col_cnt;
  logic [COL_W-1:0] row_cnt;
  logic [COL_W-1:0] c_cur;
  logic [COL_W-1:0] r_cur;
  logic             col_last;
  logic             row_last;
  logic             accept;

  logic             f_valid;
  logic [PIX_W-1:0] f_px;
  logic [COL_W-1:0] f_c;
  logic [COL_W-1:0] f_r;
  logic             f_col_last;
  logic             f_row_last;
  logic             f_go;

  logic [PIX_W-1:0] lb0 [MAX_WIDTH];
  logic [PIX_W-1:0] lb1 [MAX_WIDTH];
  logic [PIX_W-1:0] rd0_q;
  logic [PIX_W-1:0] rd1_q;
  logic             fwd_hit;
  logic [PIX_W-1:0] fwd0;
  logic [PIX_W-1:0] fwd1;
  logic [PIX_W-1:0] ld0;
  logic [PIX_W-1:0] ld1;

  window_t          win;
  window_t          win_next;
  logic             row_up;
  logic [3:0]       due;

  always_comb begin
    c_cur    = ({1'b0, col_cnt} < w_eff) ? col_cnt : COL_W'(w_eff - 1'b1);
    r_cur    = ({1'b0, row_cnt} < h_eff) ? row_cnt : COL_W'(h_eff - 1'b1);
    col_last = ({1'b0, c_cur} == w_eff - 1'b1);
    row_last = ({1'b0, r_cur} == h_eff - 1'b1);
  end

  assign f_go     = f_valid && !q_full;
  assign in_stall = f_valid && q_full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
      f_valid <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      if (accept) begin
        if (col_last) begin
          col_cnt <= '0;
          row_cnt <= row_last ? '0 : r_cur + 1'b1;
        end else begin
          col_cnt <= c_cur + 1'b1;
          row_cnt <= r_cur;
        end
        // a write landing at the same edge as the read leaves the read stale
        fwd_hit <= f_go && (f_c == c_cur);
        f_valid <= 1'b1;
      end else if (f_go) begin
        f_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_px       <= pixel_in;
      f_c        <= c_cur;
      f_r        <= r_cur;
      f_col_last <= col_last;
      f_row_last <= row_last;
      fwd0       <= f_px;
      fwd1       <= ld0;
    end
  end

  assign ld0 = fwd_hit ? fwd0 : rd0_q;
  assign ld1 = fwd_hit ? fwd1 : rd1_q;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd0_q <= lb0[c_cur];
      rd1_q <= lb1[c_cur];
    end
    if (f_go) begin
      lb0[f_c] <= f_px;
      lb1[f_c] <= ld0;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_next[k][0] = win[k][1];
      win_next[k][1] = win[k][2];
    end
    win_next[0][2] = ld1;
    win_next[1][2] = ld0;
    win_next[2][2] = f_px;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (f_go) begin
      win <= win_next;
    end
  end

  always_comb begin
    row_up = (f_r != '0);
    due[0] = row_up && (f_c != '0);
    due[1] = row_up && f_col_last;
    due[2] = f_row_last && (f_c != '0);
    due[3] = f_row_last && f_col_last;
    push_job.win     = win_next;
    push_job.col     = f_c;
    push_job.row     = f_r;
    push_job.due     = due;
    push_job.col_is0 = (f_c == '0);
    push_job.col_is1 = (f_c == COL_W'(1));
    push_job.row_is0 = (f_r == '0);
    push_job.row_is1 = (f_r == COL_W'(1));
  end

  assign push = f_go && (due != '0);

endmodule

`default_nettype wire

// ===== src/gb3_queue.sv =====
// Short job queue between the front end and the blur datapath.
// Depends on gb3_pkg.
`default_nettype none

module gb3_queue
  import gb3_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      push_job,
  output logic      full,
  input  wire logic pop,
  output job_t      head,
  output logic      empty
);

  job_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   count;

  assign full  = (count == (Q_PTR_W+1)'(Q_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

endmodule

`default_nettype wire

// ===== src/gb3_back.sv =====
// Back end: expands each job into its results and runs the weighted sum
// through a three-stage pipeline (select/add, multiply, sum/saturate). Depends on gb3_pkg.
`default_nettype none

module gb3_back
  import gb3_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [WGT_W-1:0] weight_center,
  input  wire logic [WGT_W-1:0] weight_edge,
  input  wire logic [WGT_W-1:0] weight_corner,
  input  job_t                  head,
  input  wire logic             empty,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [PIX_W-1:0]      blurred_pixel,
  output logic [COL_W-1:0]      out_col,
  output logic [COL_W-1:0]      out_row,
  output logic                  last_of_run,
  output logic                  frame_done
);

  logic             en;
  logic             issue;
  logic [3:0]       issued;
  logic [3:0]       remaining;
  logic [3:0]       pick;
  logic             last;
  logic             pass1;
  logic             right;
  logic [1:0]       ri;
  logic [1:0]       cj;
  logic [1:0]       up;
  logic [1:0]       lf;

  logic              v1;
  logic [PIX_W-1:0]  s1_ctr;
  logic [NSUM_W-1:0] s1_edge;
  logic [NSUM_W-1:0] s1_corn;
  logic [COL_W-1:0]  s1_col;
  logic [COL_W-1:0]  s1_row;
  logic              s1_last;
  logic              s1_done;

  logic                    v2;
  logic [WGT_W+PIX_W-1:0]  p_ctr;
  logic [WGT_W+NSUM_W-1:0] p_edge;
  logic [WGT_W+NSUM_W-1:0] p_corn;
  logic [COL_W-1:0]        s2_col;
  logic [COL_W-1:0]        s2_row;
  logic                    s2_last;
  logic                    s2_done;

  logic [SUM_W-1:0]  total;

  assign en    = !out_valid || !out_stall;
  assign issue = en && !empty;

  always_comb begin
    remaining = head.due & ~issued;
    pick      = remaining & (~remaining + 1'b1);
    last      = ((remaining & ~pick) == '0);
    pass1     = pick[2] || pick[3];
    right     = pick[1] || pick[3];
    ri        = pass1 ? 2'd2 : 2'd1;
    cj        = right ? 2'd2 : 2'd1;
    if (pass1) up = head.row_is0 ? 2'd2 : 2'd1;
    else       up = head.row_is1 ? 2'd1 : 2'd0;
    if (right) lf = head.col_is0 ? 2'd2 : 2'd1;
    else       lf = head.col_is1 ? 2'd1 : 2'd0;
  end

  assign pop = issue && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      issued    <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      if (issue) issued <= last ? '0 : (issued | pick);
      v1        <= !empty;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ctr  <= head.win[ri][cj];
      s1_edge <= NSUM_W'(head.win[up][cj]) + NSUM_W'(head.win[2][cj])
               + NSUM_W'(head.win[ri][lf]) + NSUM_W'(head.win[ri][2]);
      s1_corn <= NSUM_W'(head.win[up][lf]) + NSUM_W'(head.win[up][2])
               + NSUM_W'(head.win[2][lf]) + NSUM_W'(head.win[2][2]);
      s1_col  <= right ? head.col : head.col - 1'b1;
      s1_row  <= pass1 ? head.row : head.row - 1'b1;
      s1_last <= last;
      s1_done <= pick[3];

      p_ctr   <= weight_center * s1_ctr;
      p_edge  <= weight_edge * s1_edge;
      p_corn  <= weight_corner * s1_corn;
      s2_col  <= s1_col;
      s2_row  <= s1_row;
      s2_last <= s1_last;
      s2_done <= s1_done;

      // truncate the fraction, clamp at full scale
      blurred_pixel <= (total[SUM_W-1:FRAC_BITS+PIX_W] != '0) ? '1
                       : total[FRAC_BITS +: PIX_W];
      out_col       <= s2_col;
      out_row       <= s2_row;
      last_of_run   <= s2_last;
      frame_done    <= s2_done;
    end
  end

  assign total = SUM_W'(p_ctr) + SUM_W'(p_edge) + SUM_W'(p_corn);

endmodule

`default_nettype wire

// ===== src/gaussian_blur_3x3.sv =====
// 3x3 Gaussian blur, edge-clamped, over a raster stream of 8-bit pixels.
// Throughput: one pixel per clock; results leave one per clock while out_stall is low,
// so row ends and the last row (two results per pixel) fill the 4-entry job queue and
// then stall the input.
// Reset: config registers to defaults, counters, window and handshakes cleared; the
// line buffers are not cleared and need no clearing pass.
`default_nettype none

module gaussian_blur_3x3
  import gb3_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [PIX_W-1:0]     pixel_in,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [PIX_W-1:0]          blurred_pixel,
  output logic [COL_W-1:0]          out_col,
  output logic [COL_W-1:0]          out_row,
  output logic                      last_of_run,
  output logic                      frame_done
);

  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [WGT_W-1:0] weight_center;
  logic [WGT_W-1:0] weight_edge;
  logic [WGT_W-1:0] weight_corner;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  job_t push_job;
  job_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= RST_WIDTH;
      image_height  <= RST_HEIGHT;
      weight_center <= RST_WC;
      weight_edge   <= RST_WE;
      weight_corner <= RST_WK;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH:  image_width   <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: image_height  <= cfg_data[DIM_W-1:0];
        REG_WC:     weight_center <= cfg_data;
        REG_WE:     weight_edge   <= cfg_data;
        REG_WK:     weight_corner <= cfg_data;
        default:    ;
      endcase
    end
  end

  // zero means one, anything past the limit is the limit
  always_comb begin
    priority if (image_width == '0)                     w_eff = DIM_W'(1);
    else if (image_width > DIM_W'(MAX_WIDTH))            w_eff = DIM_W'(MAX_WIDTH);
    else                                                w_eff = image_width;
    priority if (image_height == '0)                    h_eff = DIM_W'(1);
    else if (image_height > DIM_W'(MAX_ROWS))            h_eff = DIM_W'(MAX_ROWS);
    else                                                h_eff = image_height;
  end

  gb3_front u_front (
    .clk      (clk),
    .rst      (rst),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .pixel_in (pixel_in),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  gb3_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  gb3_back u_back (
    .clk           (clk),
    .rst           (rst),
    .weight_center (weight_center),
    .weight_edge   (weight_edge),
    .weight_corner (weight_corner),
    .head          (head),
    .empty         (q_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .blurred_pixel (blurred_pixel),
    .out_col       (out_col),
    .out_row       (out_row),
    .last_of_run   (last_of_run),
    .frame_done    (frame_done)
  );

endmodule

`default_nettype wire

// ===== src/gb3_checker.sv =====
// Port-level checks for gaussian_blur_3x3, attached by bind.
// Depends on gb3_pkg.
`default_nettype none

module gb3_checker
  import gb3_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             cfg_ready,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [PIX_W-1:0] blurred_pixel,
  input wire logic [COL_W-1:0] out_col,
  input wire logic [COL_W-1:0] out_row,
  input wire logic             last_of_run,
  input wire logic             frame_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(blurred_pixel)
      && $stable(out_col) && $stable(out_row) && $stable(last_of_run))
    else $error("stalled result changed");

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> last_of_run)
    else $error("frame end not last of its transaction");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result right after reset");

  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind gaussian_blur_3x3 gb3_checker u_gb3_checker (
  .clk           (clk),
  .rst           (rst),
  .cfg_ready     (cfg_ready),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .blurred_pixel (blurred_pixel),
  .out_col       (out_col),
  .out_row       (out_row),
  .last_of_run   (last_of_run),
  .frame_done    (frame_done)
);

`default_nettype wire
